// ===== hw/rtl/pra_pkg.sv =====
`timescale 1ns / 1ps

package pra_pkg;

  localparam int CORD_STEPS = 30;

  typedef logic signed [31:0] coord_t;   // Q16.16 coordinate, Q2.30 axis/sin/cos
  typedef logic signed [32:0] diff_t;    // coordinate difference
  typedef logic signed [33:0] mid_t;     // saturated intermediate (k, w, u)
  typedef logic signed [33:0] cxy_t;     // CORDIC x/y
  typedef logic signed [65:0] prod_t;    // raw product
  typedef logic signed [35:0] rnd_t;     // product rounded back to Q.30
  typedef logic signed [37:0] acc_t;     // sum of a few rounded products

  localparam cxy_t   CORD_GAIN  = 34'sd652032874;
  localparam coord_t ONE_Q30    = 32'sd1073741824;
  localparam mid_t   MID_LIM    = 34'sd8589934591;
  localparam prod_t  HALF_Q30   = 66'sd536870912;
  localparam acc_t   COORD_MAX  = 38'sd2147483647;
  localparam acc_t   COORD_MIN  = -38'sd2147483648;
  localparam coord_t TO_Z_RESET = 32'sd65536;

  // configuration register indexes
  localparam logic [2:0] REG_FROM_X = 3'd0;
  localparam logic [2:0] REG_FROM_Y = 3'd1;
  localparam logic [2:0] REG_FROM_Z = 3'd2;
  localparam logic [2:0] REG_TO_X   = 3'd3;
  localparam logic [2:0] REG_TO_Y   = 3'd4;
  localparam logic [2:0] REG_TO_Z   = 3'd5;

  typedef enum logic [2:0] {
    AX_IDLE,
    AX_PREP,
    AX_SHIFT,
    AX_SQUARE,
    AX_SQRT,
    AX_DIV,
    AX_NORM
  } ax_state_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   zero;
  } axis_info_t;

  typedef struct packed {
    mid_t k;
    mid_t w0;
    mid_t w1;
    mid_t w2;
    mid_t u0;
    mid_t u1;
    mid_t u2;
  } vec_res_t;

  // Q2.30 product, rounded half up
  function automatic rnd_t round_q30(prod_t p);
    prod_t t;
    t = p + HALF_Q30;
    return t[65:30];
  endfunction

  function automatic mid_t sat_mid(acc_t s);
    if (s > MID_LIM) begin
      return MID_LIM;
    end else if (s < -MID_LIM) begin
      return -MID_LIM;
    end
    return s[33:0];
  endfunction

  function automatic coord_t sat_coord(acc_t s);
    if (s > COORD_MAX) begin
      return COORD_MAX[31:0];
    end else if (s < COORD_MIN) begin
      return COORD_MIN[31:0];
    end
    return s[31:0];
  endfunction

  function automatic coord_t sat_unit(cxy_t v);
    if (v > ONE_Q30) begin
      return ONE_Q30;
    end else if (v < -ONE_Q30) begin
      return -ONE_Q30;
    end
    return v[31:0];
  endfunction

  // atan(2^-i) in turns, 2^32 per turn
  function automatic logic [29:0] atan_turn(int unsigned i);
    logic [29:0] r;
    case (i)
      0:  r = 30'h20000000;
      1:  r = 30'h12E4051E;
      2:  r = 30'h09FB385B;
      3:  r = 30'h051111D4;
      4:  r = 30'h028B0D43;
      5:  r = 30'h0145D7E1;
      6:  r = 30'h00A2F61E;
      7:  r = 30'h00517C55;
      8:  r = 30'h0028BE53;
      9:  r = 30'h00145F2F;
      10: r = 30'h000A2F98;
      11: r = 30'h000517CC;
      12: r = 30'h00028BE6;
      13: r = 30'h000145F3;
      14: r = 30'h0000A2FA;
      15: r = 30'h0000517D;
      16: r = 30'h000028BE;
      17: r = 30'h0000145F;
      18: r = 30'h00000A30;
      19: r = 30'h00000518;
      20: r = 30'h0000028C;
      21: r = 30'h00000146;
      22: r = 30'h000000A3;
      23: r = 30'h00000051;
      24: r = 30'h00000029;
      25: r = 30'h00000014;
      26: r = 30'h0000000A;
      27: r = 30'h00000005;
      28: r = 30'h00000003;
      29: r = 30'h00000001;
      default: r = 30'h0;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/pra_axis.sv =====
`timescale 1ns / 1ps

// Config registers plus the unit-axis solver (shift, square, sqrt, divide, scale).
module pra_axis (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  output pra_pkg::coord_t     from_x,
  output pra_pkg::coord_t     from_y,
  output pra_pkg::coord_t     from_z,
  output pra_pkg::axis_info_t axis_info,
  output logic                busy
);

  localparam logic [5:0] SQRT_START = 6'd31;
  localparam logic [5:0] DIV_START  = 6'd60;
  localparam logic [5:0] LAST_LANE  = 6'd2;

  pra_pkg::ax_state_t state, state_next;

  pra_pkg::coord_t to_x, to_y, to_z;
  logic [31:0] mag_x, mag_y, mag_z;
  logic        neg_x, neg_y, neg_z;
  logic [63:0] acc;
  logic [63:0] res;
  logic [63:0] bitv;
  logic [31:0] rem;
  logic [31:0] quot;
  logic [5:0]  cnt;

  pra_pkg::diff_t dx, dy, dz, ax, ay, az;
  logic [31:0] om;
  logic [31:0] sel_mag;
  logic        sel_neg;
  logic [63:0] sel_sq;
  logic [63:0] sq_try;
  logic [32:0] rem_sh;
  logic [63:0] nprod;
  logic [33:0] qv;
  pra_pkg::coord_t qs, a_val;
  logic        cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;
  assign busy      = (state != pra_pkg::AX_IDLE);

  assign dx = pra_pkg::diff_t'(to_x) - pra_pkg::diff_t'(from_x);
  assign dy = pra_pkg::diff_t'(to_y) - pra_pkg::diff_t'(from_y);
  assign dz = pra_pkg::diff_t'(to_z) - pra_pkg::diff_t'(from_z);
  assign ax = dx[32] ? -dx : dx;
  assign ay = dy[32] ? -dy : dy;
  assign az = dz[32] ? -dz : dz;

  assign om = mag_x | mag_y | mag_z;

  always_comb begin
    case (cnt[1:0])
      2'd0: begin
        sel_mag = mag_x;
        sel_neg = neg_x;
      end
      2'd1: begin
        sel_mag = mag_y;
        sel_neg = neg_y;
      end
      default: begin
        sel_mag = mag_z;
        sel_neg = neg_z;
      end
    endcase
  end

  assign sel_sq = 64'(sel_mag) * 64'(sel_mag);
  assign sq_try = res + bitv;
  assign rem_sh = {rem, (cnt == DIV_START)};
  assign nprod  = 64'(sel_mag) * 64'(quot) + 64'(pra_pkg::HALF_Q30);
  assign qv     = nprod[63:30];
  assign qs     = (qv > 34'(pra_pkg::ONE_Q30)) ? pra_pkg::ONE_Q30 : qv[31:0];
  assign a_val  = sel_neg ? -qs : qs;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pra_pkg::AX_PREP;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    if (cfg_wr) begin
      state_next = pra_pkg::AX_PREP;
    end else begin
      case (state)
        pra_pkg::AX_IDLE:   state_next = pra_pkg::AX_IDLE;
        pra_pkg::AX_PREP:   state_next = pra_pkg::AX_SHIFT;
        pra_pkg::AX_SHIFT: begin
          if (om == 32'd0) begin
            state_next = pra_pkg::AX_IDLE;
          end else if (om[31:30] == 2'b00 && om[29]) begin
            state_next = pra_pkg::AX_SQUARE;
          end
        end
        pra_pkg::AX_SQUARE: if (cnt == LAST_LANE) state_next = pra_pkg::AX_SQRT;
        pra_pkg::AX_SQRT:   if (cnt == 6'd0) state_next = pra_pkg::AX_DIV;
        pra_pkg::AX_DIV:    if (cnt == 6'd0) state_next = pra_pkg::AX_NORM;
        pra_pkg::AX_NORM:   if (cnt == LAST_LANE) state_next = pra_pkg::AX_IDLE;
        default:            state_next = pra_pkg::AX_PREP;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      from_x <= '0;
      from_y <= '0;
      from_z <= '0;
      to_x   <= '0;
      to_y   <= '0;
      to_z   <= pra_pkg::TO_Z_RESET;
    end else if (cfg_wr) begin
      case (cfg_index)
        pra_pkg::REG_FROM_X: from_x <= cfg_data;
        pra_pkg::REG_FROM_Y: from_y <= cfg_data;
        pra_pkg::REG_FROM_Z: from_z <= cfg_data;
        pra_pkg::REG_TO_X:   to_x   <= cfg_data;
        pra_pkg::REG_TO_Y:   to_y   <= cfg_data;
        pra_pkg::REG_TO_Z:   to_z   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      pra_pkg::AX_PREP: begin
        mag_x <= ax[31:0];
        mag_y <= ay[31:0];
        mag_z <= az[31:0];
        neg_x <= dx[32];
        neg_y <= dy[32];
        neg_z <= dz[32];
      end
      pra_pkg::AX_SHIFT: begin
        // walk the largest magnitude into [2^29, 2^30)
        if (om[31:30] != 2'b00) begin
          mag_x <= mag_x >> 1;
          mag_y <= mag_y >> 1;
          mag_z <= mag_z >> 1;
        end else if (!om[29]) begin
          mag_x <= mag_x << 1;
          mag_y <= mag_y << 1;
          mag_z <= mag_z << 1;
        end
        if (om == 32'd0) begin
          axis_info.zero <= 1'b1;
        end
        acc <= '0;
        cnt <= '0;
      end
      pra_pkg::AX_SQUARE: begin
        acc <= acc + sel_sq;
        cnt <= cnt + 6'd1;
        if (cnt == LAST_LANE) begin
          res  <= '0;
          bitv <= 64'd1 << 62;
          cnt  <= SQRT_START;
        end
      end
      pra_pkg::AX_SQRT: begin
        if (acc >= sq_try) begin
          acc <= acc - sq_try;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        cnt  <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          rem <= '0;
          cnt <= DIV_START;
        end
      end
      pra_pkg::AX_DIV: begin
        // 2^60 / sqrt, one quotient bit per cycle
        if (rem_sh >= {1'b0, res[31:0]}) begin
          rem  <= 32'(rem_sh - {1'b0, res[31:0]});
          quot <= {quot[30:0], 1'b1};
        end else begin
          rem  <= rem_sh[31:0];
          quot <= {quot[30:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          cnt <= '0;
        end
      end
      pra_pkg::AX_NORM: begin
        case (cnt[1:0])
          2'd0:    axis_info.x <= a_val;
          2'd1:    axis_info.y <= a_val;
          default: axis_info.z <= a_val;
        endcase
        axis_info.zero <= 1'b0;
        cnt <= cnt + 6'd1;
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/pra_vec.sv =====
`timescale 1ns / 1ps

// Five stages: offset, products, k and w, products, u.
module pra_vec #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  pra_pkg::coord_t       point_x,
  input  pra_pkg::coord_t       point_y,
  input  pra_pkg::coord_t       point_z,
  input  logic [ANGLE_BITS-1:0] angle,
  input  pra_pkg::coord_t       from_x,
  input  pra_pkg::coord_t       from_y,
  input  pra_pkg::coord_t       from_z,
  input  pra_pkg::axis_info_t   axis_info,
  output logic                  out_valid,
  output logic [ANGLE_BITS-1:0] out_angle,
  output pra_pkg::vec_res_t     out_res
);

  logic v1, v2, v3, v4;
  logic [ANGLE_BITS-1:0] ang1, ang2, ang3, ang4;
  pra_pkg::diff_t vx, vy, vz;
  pra_pkg::prod_t p_xx, p_yy, p_zz, p_yz, p_zy, p_zx, p_xz, p_xy, p_yx;
  pra_pkg::mid_t  k3, w0_3, w1_3, w2_3;
  pra_pkg::mid_t  k4, w0_4, w1_4, w2_4;
  pra_pkg::prod_t q_1z, q_2y, q_2x, q_0z, q_0y, q_1x;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vx   <= pra_pkg::diff_t'(point_x) - pra_pkg::diff_t'(from_x);
      vy   <= pra_pkg::diff_t'(point_y) - pra_pkg::diff_t'(from_y);
      vz   <= pra_pkg::diff_t'(point_z) - pra_pkg::diff_t'(from_z);
      ang1 <= angle;

      p_xx <= axis_info.x * vx;
      p_yy <= axis_info.y * vy;
      p_zz <= axis_info.z * vz;
      p_yz <= axis_info.y * vz;
      p_zy <= axis_info.z * vy;
      p_zx <= axis_info.z * vx;
      p_xz <= axis_info.x * vz;
      p_xy <= axis_info.x * vy;
      p_yx <= axis_info.y * vx;
      ang2 <= ang1;

      k3   <= pra_pkg::sat_mid(pra_pkg::acc_t'(pra_pkg::round_q30(p_xx))
                             + pra_pkg::acc_t'(pra_pkg::round_q30(p_yy))
                             + pra_pkg::acc_t'(pra_pkg::round_q30(p_zz)));
      w0_3 <= pra_pkg::sat_mid(pra_pkg::acc_t'(pra_pkg::round_q30(p_yz))
                             - pra_pkg::acc_t'(pra_pkg::round_q30(p_zy)));
      w1_3 <= pra_pkg::sat_mid(pra_pkg::acc_t'(pra_pkg::round_q30(p_zx))
                             - pra_pkg::acc_t'(pra_pkg::round_q30(p_xz)));
      w2_3 <= pra_pkg::sat_mid(pra_pkg::acc_t'(pra_pkg::round_q30(p_xy))
                             - pra_pkg::acc_t'(pra_pkg::round_q30(p_yx)));
      ang3 <= ang2;

      q_1z <= w1_3 * axis_info.z;
      q_2y <= w2_3 * axis_info.y;
      q_2x <= w2_3 * axis_info.x;
      q_0z <= w0_3 * axis_info.z;
      q_0y <= w0_3 * axis_info.y;
      q_1x <= w1_3 * axis_info.x;
      k4   <= k3;
      w0_4 <= w0_3;
      w1_4 <= w1_3;
      w2_4 <= w2_3;
      ang4 <= ang3;

      out_res.k  <= k4;
      out_res.w0 <= w0_4;
      out_res.w1 <= w1_4;
      out_res.w2 <= w2_4;
      out_res.u0 <= pra_pkg::sat_mid(pra_pkg::acc_t'(pra_pkg::round_q30(q_1z))
                                   - pra_pkg::acc_t'(pra_pkg::round_q30(q_2y)));
      out_res.u1 <= pra_pkg::sat_mid(pra_pkg::acc_t'(pra_pkg::round_q30(q_2x))
                                   - pra_pkg::acc_t'(pra_pkg::round_q30(q_0z)));
      out_res.u2 <= pra_pkg::sat_mid(pra_pkg::acc_t'(pra_pkg::round_q30(q_0y))
                                   - pra_pkg::acc_t'(pra_pkg::round_q30(q_1x)));
      out_angle  <= ang4;
    end
  end

endmodule

// ===== hw/rtl/pra_cordic.sv =====
`timescale 1ns / 1ps

// Pipelined rotation-mode CORDIC, one step per stage, side payload rides along.
module pra_cordic #(
  parameter int ANGLE_BITS = 16,
  parameter int SIDE_W     = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [ANGLE_BITS-1:0] angle,
  input  logic [SIDE_W-1:0]     in_side,
  output logic                  out_valid,
  output pra_pkg::coord_t       cos_val,
  output pra_pkg::coord_t       sin_val,
  output logic [SIDE_W-1:0]     out_side
);

  localparam int N = pra_pkg::CORD_STEPS;

  pra_pkg::cxy_t   x    [N+1];
  pra_pkg::cxy_t   y    [N+1];
  pra_pkg::coord_t z    [N+1];
  logic [1:0]      quad [N+1];
  logic [SIDE_W-1:0] side [N+1];
  logic            vld  [N+1];

  logic [31:0]     t;
  pra_pkg::coord_t xs, ys;

  assign t  = {angle, {(32 - ANGLE_BITS){1'b0}}};
  assign xs = pra_pkg::sat_unit(x[N]);
  assign ys = pra_pkg::sat_unit(y[N]);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x[0]    <= pra_pkg::CORD_GAIN;
      y[0]    <= '0;
      z[0]    <= {2'b00, t[29:0]};
      quad[0] <= t[31:30];
      side[0] <= in_side;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!z[i][31]) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - pra_pkg::coord_t'({2'b00, pra_pkg::atan_turn(i)});
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + pra_pkg::coord_t'({2'b00, pra_pkg::atan_turn(i)});
        end
        quad[i+1] <= quad[i];
        side[i+1] <= side[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[N];
    end
  end

  // quadrant fold back
  always_ff @(posedge clk) begin
    if (en) begin
      case (quad[N])
        2'd0: begin
          cos_val <= xs;
          sin_val <= ys;
        end
        2'd1: begin
          cos_val <= -ys;
          sin_val <= xs;
        end
        2'd2: begin
          cos_val <= -xs;
          sin_val <= -ys;
        end
        default: begin
          cos_val <= ys;
          sin_val <= -xs;
        end
      endcase
      out_side <= side[N];
    end
  end

endmodule

// ===== hw/rtl/pra_final.sv =====
`timescale 1ns / 1ps

// Two stages: k*a, cos*u, sin*w products, then sum, shift back, saturate.
module pra_final (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  pra_pkg::coord_t     cos_val,
  input  pra_pkg::coord_t     sin_val,
  input  pra_pkg::vec_res_t   res,
  input  pra_pkg::axis_info_t axis_info,
  input  pra_pkg::coord_t     from_x,
  input  pra_pkg::coord_t     from_y,
  input  pra_pkg::coord_t     from_z,
  output logic                out_valid,
  output pra_pkg::coord_t     rotated_x,
  output pra_pkg::coord_t     rotated_y,
  output pra_pkg::coord_t     rotated_z,
  output logic                zero_axis
);

  logic v1;
  logic zero1;
  pra_pkg::prod_t kax, kay, kaz, cux, cuy, cuz, swx, swy, swz;
  pra_pkg::acc_t  sx, sy, sz;

  assign sx = pra_pkg::acc_t'(pra_pkg::round_q30(kax)) + pra_pkg::acc_t'(pra_pkg::round_q30(cux))
            + pra_pkg::acc_t'(pra_pkg::round_q30(swx)) + pra_pkg::acc_t'(from_x);
  assign sy = pra_pkg::acc_t'(pra_pkg::round_q30(kay)) + pra_pkg::acc_t'(pra_pkg::round_q30(cuy))
            + pra_pkg::acc_t'(pra_pkg::round_q30(swy)) + pra_pkg::acc_t'(from_y);
  assign sz = pra_pkg::acc_t'(pra_pkg::round_q30(kaz)) + pra_pkg::acc_t'(pra_pkg::round_q30(cuz))
            + pra_pkg::acc_t'(pra_pkg::round_q30(swz)) + pra_pkg::acc_t'(from_z);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kax   <= res.k * axis_info.x;
      kay   <= res.k * axis_info.y;
      kaz   <= res.k * axis_info.z;
      cux   <= cos_val * res.u0;
      cuy   <= cos_val * res.u1;
      cuz   <= cos_val * res.u2;
      swx   <= sin_val * res.w0;
      swy   <= sin_val * res.w1;
      swz   <= sin_val * res.w2;
      zero1 <= axis_info.zero;

      rotated_x <= zero1 ? from_x : pra_pkg::sat_coord(sx);
      rotated_y <= zero1 ? from_y : pra_pkg::sat_coord(sy);
      rotated_z <= zero1 ? from_z : pra_pkg::sat_coord(sz);
      zero_axis <= zero1;
    end
  end

endmodule

// ===== hw/rtl/point_rotation_about_axis_core.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  point_x/y/z, rotation_angle
// out       output     out_valid / out_stall rotated_x/y/z, zero_axis
// cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One point per cycle while in_stall is low (5 vector stages, 32 CORDIC, 2 final).
// After reset and after every config transfer the axis solver runs (shift walk,
// 3 squares, 32 sqrt steps, 61 divide steps, 3 scales); in_stall stays high
// meanwhile. Config transfers are always taken.
// A stalled output freezes the whole pipeline; the result holds in place.
// Reset is synchronous; it clears valid bits and the config registers, except to_z = 1.0.
module point_rotation_about_axis_core #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [31:0]    point_x,
  input  logic signed [31:0]    point_y,
  input  logic signed [31:0]    point_z,
  input  logic [ANGLE_BITS-1:0] rotation_angle,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [31:0]    rotated_x,
  output logic signed [31:0]    rotated_y,
  output logic signed [31:0]    rotated_z,
  output logic                  zero_axis,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [31:0]           cfg_data
);

  localparam int SIDE_W = $bits(pra_pkg::vec_res_t);

  logic en;
  logic axis_busy;
  pra_pkg::coord_t     from_x, from_y, from_z;
  pra_pkg::axis_info_t axis_info;

  logic                  vec_valid;
  logic [ANGLE_BITS-1:0] vec_angle;
  pra_pkg::vec_res_t     vec_res;

  logic              cor_valid;
  pra_pkg::coord_t   cos_val, sin_val;
  logic [SIDE_W-1:0] cor_side;

  // whole pipeline moves unless a finished result is being held
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en || axis_busy;

  pra_axis u_axis (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .from_x    (from_x),
    .from_y    (from_y),
    .from_z    (from_z),
    .axis_info (axis_info),
    .busy      (axis_busy)
  );

  // v = p - from; k = a.v; w = a x v; u = w x a
  pra_vec #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_vec (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid && !in_stall),
    .point_x   (point_x),
    .point_y   (point_y),
    .point_z   (point_z),
    .angle     (rotation_angle),
    .from_x    (from_x),
    .from_y    (from_y),
    .from_z    (from_z),
    .axis_info (axis_info),
    .out_valid (vec_valid),
    .out_angle (vec_angle),
    .out_res   (vec_res)
  );

  // sin/cos of the binary angle; k, w, u ride along as side payload
  pra_cordic #(
    .ANGLE_BITS (ANGLE_BITS),
    .SIDE_W     (SIDE_W)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vec_valid),
    .angle     (vec_angle),
    .in_side   (vec_res),
    .out_valid (cor_valid),
    .cos_val   (cos_val),
    .sin_val   (sin_val),
    .out_side  (cor_side)
  );

  // from + k*a + cos*u + sin*w, saturated; the last stage is the output register
  pra_final u_final (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (cor_valid),
    .cos_val   (cos_val),
    .sin_val   (sin_val),
    .res       (pra_pkg::vec_res_t'(cor_side)),
    .axis_info (axis_info),
    .from_x    (from_x),
    .from_y    (from_y),
    .from_z    (from_z),
    .out_valid (out_valid),
    .rotated_x (rotated_x),
    .rotated_y (rotated_y),
    .rotated_z (rotated_z),
    .zero_axis (zero_axis)
  );

  // a config transfer must hold off input until the axis is solved again
  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> in_stall)
    else $error("input not held off after config transfer");

  // a solved, non-degenerate axis has every component within +-1.0
  a_axis_range: assert property (@(posedge clk) disable iff (rst)
    !axis_busy && !axis_info.zero |->
      axis_info.x <= pra_pkg::ONE_Q30 && axis_info.x >= -pra_pkg::ONE_Q30 &&
      axis_info.y <= pra_pkg::ONE_Q30 && axis_info.y >= -pra_pkg::ONE_Q30 &&
      axis_info.z <= pra_pkg::ONE_Q30 && axis_info.z >= -pra_pkg::ONE_Q30)
    else $error("axis component out of range");

  // an empty output register never blocks input unless the solver runs
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid && !axis_busy |-> !in_stall)
    else $error("input stalled with empty output");

endmodule

// ===== verif/tb_point_rotation_about_axis_core.sv =====
`timescale 1ns / 1ps

module tb_point_rotation_about_axis_core;

  // one rotated point
  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               zero;
  } rot_pt_t;

  int err_count = 0;

  // Print one line per mismatch and keep the count.
  task automatic report_err(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // Arithmetic shift right for 64-bit signed values.
  function automatic longint ashr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clampv(longint v, longint lim);
    return v > lim ? lim : (v < -lim ? -lim : v);
  endfunction

  // Q2.30 product rounded half up. Products stay below 2^33 * 2^30, so 64 bits suffice.
  function automatic longint mul30(longint a, longint b);
    return ashr(a * b + (64'sd1 <<< 29), 30);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // CORDIC sine and cosine in Q2.30 of a 16-bit binary angle.
  function automatic void angle_sincos(input logic [15:0] ang, output longint c,
                                       output longint s);
    longint tval, z, x, y, nx;
    int quad;
    tval = longint'(ang) << 16;
    quad = int'((tval >> 30) & 3);
    z = tval & 64'h3FFF_FFFF;
    x = 652032874;
    y = 0;
    for (int i = 0; i < 30; i++) begin
      if (z >= 0) begin
        nx = x - ashr(y, i); y = y + ashr(x, i); z -= longint'(pra_pkg::atan_turn(i));
      end else begin
        nx = x + ashr(y, i); y = y - ashr(x, i); z += longint'(pra_pkg::atan_turn(i));
      end
      x = nx;
    end
    x = clampv(x, 64'sd1 <<< 30);
    y = clampv(y, 64'sd1 <<< 30);
    case (quad)
      0: begin c = x;  s = y;  end
      1: begin c = -y; s = x;  end
      2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  class rotation_board;
    logic signed [31:0] axis_pts[6];   // from x/y/z, to x/y/z
    rot_pt_t pending[$];

    function new();
      foreach (axis_pts[i]) axis_pts[i] = 0;
      axis_pts[pra_pkg::REG_TO_Z] = 32'sd65536;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      if (idx <= pra_pkg::REG_TO_Z) axis_pts[idx] = val;
    endfunction

    // Rodrigues rotation of one point; pushes the expected result.
    function void note_point(logic signed [31:0] px, logic signed [31:0] py,
                             logic signed [31:0] pz, logic [15:0] ang);
      longint f[3], d[3], v[3], a[3], w[3], u[3], k, c, s, r, q;
      longint unsigned mag[3], m, sum, rec, sq;
      int len, sh;
      rot_pt_t e;
      m = 0; sum = 0; len = 0;
      for (int i = 0; i < 3; i++) begin
        f[i] = longint'(axis_pts[i]);
        d[i] = longint'(axis_pts[i+3]) - f[i];
        mag[i] = d[i] < 0 ? -d[i] : d[i];
        if (mag[i] > m) m = mag[i];
      end
      if (m == 0) begin
        e.x = f[0][31:0]; e.y = f[1][31:0]; e.z = f[2][31:0]; e.zero = 1'b1;
        pending.push_back(e);
        return;
      end
      while (len < 64 && (m >> len) != 0) len++;
      sh = 30 - len;
      for (int i = 0; i < 3; i++) begin
        mag[i] = sh >= 0 ? (mag[i] << sh) : (mag[i] >> (-sh));
        sum += mag[i] * mag[i];
      end
      sq = int_sqrt(sum);
      rec = (64'd1 << 60) / sq;
      v[0] = longint'(px) - f[0];
      v[1] = longint'(py) - f[1];
      v[2] = longint'(pz) - f[2];
      for (int i = 0; i < 3; i++) begin
        q = longint'((mag[i] * rec + (64'd1 << 29)) >> 30);
        q = clampv(q, 64'sd1 <<< 30);
        a[i] = d[i] < 0 ? -q : q;
      end
      angle_sincos(ang, c, s);
      k = clampv(mul30(a[0], v[0]) + mul30(a[1], v[1]) + mul30(a[2], v[2]),
                 pra_pkg::MID_LIM);
      w[0] = clampv(mul30(a[1], v[2]) - mul30(a[2], v[1]), pra_pkg::MID_LIM);
      w[1] = clampv(mul30(a[2], v[0]) - mul30(a[0], v[2]), pra_pkg::MID_LIM);
      w[2] = clampv(mul30(a[0], v[1]) - mul30(a[1], v[0]), pra_pkg::MID_LIM);
      u[0] = clampv(mul30(w[1], a[2]) - mul30(w[2], a[1]), pra_pkg::MID_LIM);
      u[1] = clampv(mul30(w[2], a[0]) - mul30(w[0], a[2]), pra_pkg::MID_LIM);
      u[2] = clampv(mul30(w[0], a[1]) - mul30(w[1], a[0]), pra_pkg::MID_LIM);
      for (int i = 0; i < 3; i++) begin
        r = mul30(k, a[i]) + mul30(c, u[i]) + mul30(s, w[i]) + f[i];
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        if (i == 0) e.x = r[31:0]; else if (i == 1) e.y = r[31:0]; else e.z = r[31:0];
      end
      e.zero = 1'b0;
      pending.push_back(e);
    endfunction

    task check_result(rot_pt_t got);
      rot_pt_t e;
      if (pending.size() == 0) begin
        report_err("unexpected result x", got.x, 0);
        return;
      end
      e = pending.pop_front();
      if (got.x !== e.x) report_err("rotated_x", got.x, e.x);
      if (got.y !== e.y) report_err("rotated_y", got.y, e.y);
      if (got.z !== e.z) report_err("rotated_z", got.z, e.z);
      if (got.zero !== e.zero) report_err("zero_axis", got.zero, e.zero);
    endtask
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_stall;
  logic signed [31:0] point_x = 0, point_y = 0, point_z = 0;
  logic [15:0] rotation_angle = 0;
  logic out_valid, out_stall = 0;
  logic signed [31:0] rotated_x, rotated_y, rotated_z;
  logic zero_axis;
  logic cfg_valid = 0, cfg_ready;
  logic [2:0] cfg_index = 0;
  logic [31:0] cfg_data = 0;

  rotation_board board = new();

  // receiver behavior: 0 random stalls, 1 never stall; hold_cycles forces a long hold-off
  int stall_mode = 0;
  int hold_cycles = 0;

  point_rotation_about_axis_core DUT (.*);

  initial forever #5 clk = ~clk;

  // Generous wall: solver pass per config plus 823 items at worst stall rate.
  initial begin
    #(3_000_000);
    $display("DONE: errors detected");
    $finish;
  end

  // Output side: sample at rising edge, pick stall at the falling edge.
  always @(posedge clk) begin
    rot_pt_t got;
    if (!rst && out_valid && !out_stall) begin
      got.x = rotated_x; got.y = rotated_y; got.z = rotated_z; got.zero = zero_axis;
      board.check_result(got);
    end
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles--;
    end else if (stall_mode == 1) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 3) == 0);
    end
  end

  // Register write; only issued with the pipeline drained.
  task automatic write_cfg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Offer one point and hold it until the transfer happens.
  task automatic send_point(input logic [31:0] px, input logic [31:0] py,
                            input logic [31:0] pz, input logic [15:0] ang);
    point_x <= px; point_y <= py; point_z <= pz; rotation_angle <= ang;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    board.note_point(px, py, pz, ang);
    @(negedge clk);
  endtask

  task automatic idle_input(input int n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Wait for every pending result, then the block latency before a config write.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_axis();
    for (int r = 0; r < 6; r++) begin
      write_cfg(r[2:0], $urandom_range(0, 1) ? rand_coord()
                                             : ($urandom_range(0, 32'h3F_FFFF) - 32'h20_0000));
    end
  endtask

  // Bursty stream of random points.
  task automatic random_burst_run(input int n);
    int left, burst;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 20);
      for (int i = 0; i < burst && left > 0; i++) begin
        send_point(rand_coord(), rand_coord(), rand_coord(), 16'($urandom));
        left--;
      end
      if ($urandom_range(0, 2) != 0) idle_input($urandom_range(1, 6));
    end
  endtask

  initial begin
    logic [15:0] angs[6] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF, 16'h2000};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset axis (z unit), quarter turns and angle extremes.
    stall_mode = 1;
    foreach (angs[i]) send_point(32'sd65536, 32'sd0, 32'sd131072, angs[i]);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'h1234);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 16'hEDCB);
    drain();

    // Coincident axis points flag the zero axis.
    write_cfg(pra_pkg::REG_FROM_X, 32'sd65536);
    write_cfg(pra_pkg::REG_FROM_Y, 32'sd65536);
    write_cfg(pra_pkg::REG_FROM_Z, 32'sd65536);
    write_cfg(pra_pkg::REG_TO_X, 32'sd65536);
    write_cfg(pra_pkg::REG_TO_Y, 32'sd65536);
    write_cfg(pra_pkg::REG_TO_Z, 32'sd65536);
    send_point(32'sd5, 32'sd6, 32'sd7, 16'h4000);
    send_point(32'hFFFF_FFFF, 32'h0, 32'h1, 16'h0);
    drain();

    // Widest axis: large magnitude differences that force a right shift.
    write_cfg(pra_pkg::REG_FROM_X, 32'h8000_0000);
    write_cfg(pra_pkg::REG_FROM_Y, 32'h7FFF_FFFF);
    write_cfg(pra_pkg::REG_FROM_Z, 32'h8000_0000);
    write_cfg(pra_pkg::REG_TO_X, 32'h7FFF_FFFF);
    write_cfg(pra_pkg::REG_TO_Y, 32'h8000_0000);
    write_cfg(pra_pkg::REG_TO_Z, 32'h7FFF_FFFF);
    foreach (angs[i]) send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, angs[i]);
    drain();

    // Tiny axis: one LSB difference.
    write_cfg(pra_pkg::REG_TO_X, 32'h8000_0001);
    write_cfg(pra_pkg::REG_TO_Y, 32'h7FFF_FFFF);
    write_cfg(pra_pkg::REG_TO_Z, 32'h8000_0000);
    send_point(32'h0, 32'h0, 32'h0, 16'h4000);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h8000);
    drain();

    // Random phases with different axes and receiver behavior.
    stall_mode = 0;
    for (int ph = 0; ph < 8; ph++) begin
      random_axis();
      if (ph == 2) begin
        // Long receiver hold-off while the sender keeps offering.
        hold_cycles = 300;
        random_burst_run(100);
      end else begin
        stall_mode = (ph % 3 == 1) ? 1 : 0;
        random_burst_run(95);
      end
      // Sender waits for every result before going on.
      in_valid <= 1'b0;
      while (board.pending.size() != 0) @(negedge clk);
      random_burst_run(5);
      drain();
    end

    repeat (50) @(negedge clk);
    if (err_count == 0 && board.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/pra_pkg.sv
hw/rtl/pra_axis.sv
hw/rtl/pra_vec.sv
hw/rtl/pra_cordic.sv
hw/rtl/pra_final.sv
hw/rtl/point_rotation_about_axis_core.sv
verif/tb_point_rotation_about_axis_core.sv
